/* rtl/core/smpq_pkg.sv */
package smpq_pkg;

    localparam int KEY_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int HELD_W = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // response status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the request transaction
        logic exec;   // apply it to the list and load the response register
    } t_dp_cmd;

endpackage

/* rtl/core/smpq_if.sv */
interface smpq_req_if
    import smpq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface smpq_rsp_if
    import smpq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [KEY_W-1:0]  max_key;
    logic [STAT_W-1:0]        status;
    logic [HELD_W-1:0]        entries_held;

    modport source (output valid, output max_key, output status, output entries_held,
                    input ready);
    modport sink   (input valid, input max_key, input status, input entries_held,
                    output ready);
endinterface

/* rtl/core/smpq_ctrl.sv */
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait until the response register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/smpq_dpath.sv */
module smpq_dpath
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [KEY_W-1:0]  i_key,
    output logic signed [KEY_W-1:0]  o_max_key,
    output logic [STAT_W-1:0]        o_status,
    output logic [HELD_W-1:0]        o_entries_held
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [KIND_W-1:0]        r_kind;
    logic signed [KEY_W-1:0]  r_key;
    logic [CW-1:0]            r_count, n_count;
    logic signed [KEY_W-1:0]  r_keys [CAPACITY];
    logic signed [KEY_W-1:0]  n_keys [CAPACITY];
    logic signed [KEY_W-1:0]  r_max_key, n_max_key;
    logic [STAT_W-1:0]        r_status, n_status;
    logic [HELD_W-1:0]        r_held;
    logic [CW+HELD_W-1:0]     held_ext;

    logic [CAPACITY-1:0]      gt;
    logic                     full, empty, do_ins, do_ext;

    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);
    assign do_ins = (r_kind == KIND_INSERT) && !full;
    assign do_ext = (r_kind == KIND_EXTRACT) && !empty;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
    end

    // cell array: every stored key compares against the new key in parallel;
    // gt is a prefix since the list is sorted descending
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign gt[g] = (CW'(g) < r_count) && (r_keys[g] > r_key);

            if (g == 0) begin : g_head
                always_comb begin
                    n_keys[g] = r_keys[g];
                    if (do_ins && !gt[g]) begin
                        n_keys[g] = r_key;
                    end else if (do_ext) begin
                        if (CAPACITY > 1) n_keys[g] = r_keys[(g+1) % CAPACITY];
                    end
                end
            end else begin : g_body
                always_comb begin
                    n_keys[g] = r_keys[g];
                    if (do_ins && !gt[g]) begin
                        n_keys[g] = gt[g-1] ? r_key : r_keys[g-1];
                    end else if (do_ext && (g < CAPACITY - 1)) begin
                        n_keys[g] = r_keys[(g+1) % CAPACITY];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    r_keys[g] <= n_keys[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_max_key = '0;
        n_status  = STAT_OK;
        case (r_kind)
            KIND_INSERT: begin
                if (full) n_status = STAT_FULL;
                else      n_count  = r_count + CW'(1);
            end
            KIND_EXTRACT: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_max_key = r_keys[0];
                    n_count   = r_count - CW'(1);
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign held_ext = {{HELD_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_max_key <= n_max_key;
            r_status  <= n_status;
            r_held    <= held_ext[HELD_W-1:0];
        end
    end

    assign o_max_key      = r_max_key;
    assign o_status       = r_status;
    assign o_entries_held = r_held;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && do_ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPACITY > 1) && (r_count >= CW'(2)) |-> r_keys[0] >= r_keys[1 % CAPACITY])
        else $error("head of list out of order");

endmodule

/* rtl/core/sorted_max_priority_queue_unit.sv */
// Each request transaction is first captured, then applied to the whole cell array in one step
//   (all cells compare in parallel) once the response register is free; the response is
//   registered and valid after that step, and no new request is taken until it is applied.
// The next request is taken while an earlier response still waits for its sink.
// Reset (i_rst_n, synchronous, active low) empties the queue and drops any pending response.
module sorted_max_priority_queue_unit
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smpq_req_if.sink      i_req,
    smpq_rsp_if.source    o_rsp
);

    // controller commands the datapath: capture, then execute
    t_dp_cmd cmd;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // sorted cell array, entry count and response register
    smpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_req.kind),
        .i_key          (i_req.key),
        .o_max_key      (o_rsp.max_key),
        .o_status       (o_rsp.status),
        .o_entries_held (o_rsp.entries_held)
    );

endmodule
